/* hw/rtl/sfz_pkg.sv */
// shared constants and the free-letter pick for the z-function string builder
// no dependencies
`timescale 1ns / 1ps

package sfz_pkg;

  localparam int MAX_LEN       = 1024;
  localparam int ALPHABET_SIZE = 26;
  localparam int ADDR_W        = 10;
  localparam int CNT_W         = 11;
  localparam int SYM_W         = 5;
  localparam int MASK_W        = 32;

  typedef struct packed {
    logic             none;
    logic [SYM_W-1:0] sym;
  } pick_t;

  // lowest letter from 'b' upward whose mask bit is clear
  function automatic pick_t pick_free(input logic [MASK_W-1:0] mask);
    pick_t r;
    r.none = 1'b1;
    r.sym  = '0;
    for (int s = ALPHABET_SIZE - 1; s >= 1; s--) begin
      if (!mask[s]) begin
        r.none = 1'b0;
        r.sym  = SYM_W'(s);
      end
    end
    return r;
  endfunction

endpackage

/* hw/rtl/string_from_z_function.sv */
// lexicographically least string from a z-function, one symbol per word
// depends on sfz_pkg
`timescale 1ns / 1ps

// Input channel in_valid/in_ready carries one z_value and a last flag per
// string position; output channel out_valid/out_ready returns one symbol
// (0 = 'a'), an overflow flag and last_res for each input word, in order.
// A word is taken in the idle state; copy positions, zeros that need no
// search and position 0 pass through the execute state and then the done
// state. The first zero after a copy block walks the recorded lengths
// through the length memory and then the symbol memory, one length per
// cycle in a three-deep pipeline; the block may have recorded up to 1024
// lengths, or none. Symbols and recorded lengths live in two 1024-entry
// memories with registered reads; only entries written in the current
// string are used. Reset (synchronous, active high) clears the control
// state and out_valid; the memories need no clearing pass. The result
// moves to an output register; if the receiver stalls, one more word is
// taken and computed, then the block holds it and takes no new input until
// the output register is free again. After a word with last set, cnt, br,
// cp, pos and after return to their reset values.

module string_from_z_function (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [sfz_pkg::ADDR_W-1:0] z_value,
  input  logic                      last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [sfz_pkg::SYM_W-1:0] symbol,
  output logic                      overflow,
  output logic                      last_res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_PICK,
    S_DONE
  } state_t;

  state_t state;

  logic [sfz_pkg::SYM_W-1:0]  sym_mem [sfz_pkg::MAX_LEN];
  logic [sfz_pkg::ADDR_W-1:0] fl_mem  [sfz_pkg::MAX_LEN];

  logic [sfz_pkg::ADDR_W-1:0] zr;
  logic                       lastr;
  logic [sfz_pkg::ADDR_W-1:0] copy_addr;
  logic [sfz_pkg::CNT_W-1:0]  cnt;
  logic [sfz_pkg::ADDR_W-1:0] br;
  logic [sfz_pkg::ADDR_W-1:0] cp;
  logic [sfz_pkg::ADDR_W-1:0] pos;
  logic                       after;
  logic [sfz_pkg::CNT_W-1:0]  k;
  logic                       v1;
  logic                       v2;
  logic [sfz_pkg::MASK_W-1:0] mask;
  logic [sfz_pkg::SYM_W-1:0]  res_sym;
  logic                       res_ovf;

  logic [sfz_pkg::SYM_W-1:0]  sym_rdata;
  logic [sfz_pkg::ADDR_W-1:0] sym_raddr;
  logic                       sym_we;
  logic [sfz_pkg::ADDR_W-1:0] fl_rdata;
  logic [sfz_pkg::ADDR_W-1:0] fl_raddr;
  logic                       fl_we;
  logic [sfz_pkg::ADDR_W-1:0] fl_waddr;

  logic [sfz_pkg::ADDR_W-1:0] cp_sel;
  logic                       in_acc;
  logic                       out_free;
  logic                       pos_open;
  logic                       cnt_open;
  sfz_pkg::pick_t             pick;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign cp_sel   = (z_value > br) ? '0 : cp;
  assign pos_open = (pos < sfz_pkg::ADDR_W'(sfz_pkg::MAX_LEN - 1));
  assign cnt_open = (cnt < sfz_pkg::CNT_W'(sfz_pkg::MAX_LEN));
  assign pick     = sfz_pkg::pick_free(mask);

  assign sym_raddr = (state == S_IDLE) ? cp_sel : fl_rdata;
  assign sym_we    = (state == S_DONE) && out_free && pos_open;
  assign fl_raddr  = k[sfz_pkg::ADDR_W-1:0];

  always_comb begin
    fl_we    = 1'b0;
    fl_waddr = cnt[sfz_pkg::ADDR_W-1:0];
    if (state == S_EXEC && pos != '0) begin
      if (zr > br) begin
        fl_we    = 1'b1;
        fl_waddr = '0;
      end else if (zr == br && br != '0) begin
        fl_we = cnt_open;
      end
    end
  end

  // symbol store
  always_ff @(posedge clk) begin
    if (sym_we) begin
      sym_mem[pos] <= res_sym;
    end
    sym_rdata <= sym_mem[sym_raddr];
  end

  // recorded lengths
  always_ff @(posedge clk) begin
    if (fl_we) begin
      fl_mem[fl_waddr] <= zr;
    end
    fl_rdata <= fl_mem[fl_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      br        <= '0;
      cp        <= '0;
      pos       <= '0;
      after     <= 1'b1;
      k         <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            zr        <= z_value;
            lastr     <= last;
            copy_addr <= cp_sel;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_ovf <= 1'b0;
          if (pos == '0) begin
            res_sym <= '0;
            state   <= S_DONE;
          end else if (br != '0 || zr != '0) begin
            if (zr > br) begin
              br  <= zr - 1'b1;
              cp  <= sfz_pkg::ADDR_W'(1);
              cnt <= sfz_pkg::CNT_W'(1);
            end else begin
              br <= br - 1'b1;
              cp <= cp + 1'b1;
              if (zr == br && cnt_open) begin
                cnt <= cnt + 1'b1;
              end
            end
            res_sym <= (copy_addr < pos) ? sym_rdata : '0;
            after   <= 1'b1;
            state   <= S_DONE;
          end else if (after) begin
            after <= 1'b0;
            mask  <= '0;
            k     <= '0;
            v1    <= 1'b0;
            v2    <= 1'b0;
            state <= S_WALK;
          end else begin
            res_sym <= sfz_pkg::SYM_W'(1);
            state   <= S_DONE;
          end
        end
        S_WALK: begin
          // issue length read, then symbol read, then fold into mask
          if (k < cnt) begin
            k  <= k + 1'b1;
            v1 <= 1'b1;
          end else begin
            v1 <= 1'b0;
          end
          v2 <= v1 && (fl_rdata < pos);
          if (v2) begin
            mask[sym_rdata] <= 1'b1;
          end
          if (k >= cnt && !v1 && !v2) begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          res_sym <= pick.sym;
          res_ovf <= pick.none;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            symbol   <= res_sym;
            overflow <= res_ovf;
            last_res <= lastr;
            if (lastr) begin
              cnt   <= '0;
              br    <= '0;
              cp    <= '0;
              pos   <= '0;
              after <= 1'b1;
            end else if (pos_open) begin
              pos <= pos + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // one word in flight at a time
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("input taken while a word is in flight");

  a_sym_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (symbol < sfz_pkg::SYM_W'(sfz_pkg::ALPHABET_SIZE)))
    else $error("symbol outside the alphabet");

  a_ovf_sym: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (symbol == '0))
    else $error("overflow with a nonzero symbol");

  a_walk_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK) |-> (!v1 && !v2 && k >= cnt))
    else $error("pick before the length walk drained");

endmodule
